// File: hw/rtl/npcs_pkg.sv
// shared types, constants and colour expansion tables for the nearest palette colour search
// no dependencies; imported by every module of the block except npcs_ram

package npcs_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int CH_W            = 16;
	localparam int DIST_W          = 18;
	localparam int SIZE_W          = 4;
	localparam int LG_MAX          = 8;
	localparam int CNT_W           = LG_MAX + 1;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;
	localparam int Q_DEPTH         = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(LG_MAX);

	// register index taken from paddr[2]
	localparam logic REG_PALETTE_SIZE_LOG2 = 1'b0;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic            kind;
		logic [7:0]      entry_index;
		logic [CH_W-1:0] entry_red;
		logic [CH_W-1:0] entry_green;
		logic [CH_W-1:0] entry_blue;
		logic            entry_exact;
		logic            entry_shared;
		logic [7:0]      colour_code;
	} npcs_in_t;

	typedef struct packed {
		logic [7:0]        nearest_entry;
		logic [DIST_W-1:0] min_distance;
		logic              found;
		logic              first_shared_use;
	} npcs_out_t;

	// one palette entry as stored in the colour memory
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            exact;
		logic            shared;
	} npcs_entry_t;

	localparam int ENTRY_W = $bits(npcs_entry_t);

	// classified request; colour fields hold the expanded targets for a query
	typedef struct packed {
		logic            is_query;
		logic            load_ok;
		logic [7:0]      index;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            exact;
		logic            shared;
	} npcs_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_RESULT
	} npcs_state_t;

	typedef struct packed {
		logic idle;
		logic in_result;
	} npcs_stat_t;

	// v * 65535 / 7, truncated
	function automatic logic [CH_W-1:0] expand3(input logic [2:0] v);
		logic [CH_W-1:0] r;
		case (v)
			3'd0: r = 16'd0;
			3'd1: r = 16'd9362;
			3'd2: r = 16'd18724;
			3'd3: r = 16'd28086;
			3'd4: r = 16'd37448;
			3'd5: r = 16'd46810;
			3'd6: r = 16'd56172;
			default: r = 16'd65535;
		endcase
		return r;
	endfunction

	// v * 65535 / 3
	function automatic logic [CH_W-1:0] expand2(input logic [1:0] v);
		logic [CH_W-1:0] r;
		case (v)
			2'd0: r = 16'd0;
			2'd1: r = 16'd21845;
			2'd2: r = 16'd43690;
			default: r = 16'd65535;
		endcase
		return r;
	endfunction

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// File: hw/rtl/npcs_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies

module npcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/npcs_front.sv
// front end: takes requests, classifies load or query, expands query codes to targets
// depends on npcs_pkg

module npcs_front import npcs_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic      item_valid,
	output logic      item_stall,
	input  npcs_in_t  item,
	input  logic      q_full,
	output logic      push,
	output npcs_cmd_t cmd
);

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

	always_comb begin
		cmd.is_query = (item.kind == KIND_QUERY);
		cmd.load_ok  = ({1'b0, item.entry_index} < CNT_W'(MAX_ENTRIES));
		cmd.index    = item.entry_index;
		cmd.exact    = item.entry_exact;
		cmd.shared   = item.entry_shared;
		if (item.kind == KIND_QUERY) begin
			cmd.red   = expand3(item.colour_code[2:0]);
			cmd.green = expand3(item.colour_code[5:3]);
			cmd.blue  = expand2(item.colour_code[7:6]);
		end else begin
			cmd.red   = item.entry_red;
			cmd.green = item.entry_green;
			cmd.blue  = item.entry_blue;
		end
	end

endmodule

// File: hw/rtl/npcs_queue.sv
// short request queue between the front end and the search engine
// depends on npcs_pkg

module npcs_queue import npcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  npcs_cmd_t din,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output npcs_cmd_t dout
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_QW = $clog2(Q_DEPTH + 1);

	npcs_cmd_t          slot_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;

	assign full      = (count_q == CNT_QW'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/npcs_back.sv
// search engine: writes palette entries, walks them one per cycle for a query,
// holds the result register; depends on npcs_pkg and npcs_ram

module npcs_back import npcs_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SIZE_W-1:0] size_log2,
	input  logic              cmd_valid,
	input  npcs_cmd_t         cmd,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output npcs_out_t         result,
	output npcs_stat_t        stat
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);

	npcs_state_t state_q, state_d;

	logic [MAX_ENTRIES-1:0] ent_vld_q;
	logic [MAX_ENTRIES-1:0] used_q;
	logic [IDX_W-1:0]       last_nearest_q;

	logic [CH_W-1:0]   tr_q, tg_q, tb_q;
	logic [IDX_W-1:0]  addr_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic [IDX_W-1:0]  best_q;
	logic [DIST_W-1:0] best_d_q;
	logic              found_q;

	logic              act_s1, vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              act_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [CH_W-1:0]   dr_s2, dg_s2, db_s2;
	logic              act_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [DIST_W-1:0] sum_s3;

	logic              result_valid_q;
	npcs_out_t         result_q;

	logic              start, we, rd_en, scan_rd, emit;
	logic [IDX_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rdata;
	npcs_entry_t       ent_rd;
	npcs_entry_t       ent_wr;
	logic              elig;
	logic [SIZE_W-1:0] lg_c;
	logic [CNT_W-1:0]  n_c;
	logic [IDX_W-1:0]  last_idx_c;

	assign ent_wr.red    = cmd.red;
	assign ent_wr.green  = cmd.green;
	assign ent_wr.blue   = cmd.blue;
	assign ent_wr.exact  = cmd.exact;
	assign ent_wr.shared = cmd.shared;

	npcs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_colour_ram (
		.clk   (clk),
		.we    (we),
		.waddr (IDX_W'(cmd.index)),
		.wdata (ent_wr),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign ent_rd = npcs_entry_t'(rdata);
	assign elig   = vld_s1 && (ent_rd.exact || ent_rd.shared);

	// number of entries searched: 2^min(size, 8), capped at the palette depth
	always_comb begin
		lg_c = (size_log2 > SIZE_W'(LG_MAX)) ? SIZE_W'(LG_MAX) : size_log2;
		n_c  = CNT_W'(1) << lg_c;
		if (n_c > CNT_W'(MAX_ENTRIES)) begin
			n_c = CNT_W'(MAX_ENTRIES);
		end
		last_idx_c = IDX_W'(n_c - CNT_W'(1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.is_query) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (addr_q == last_idx_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!act_s1 && !act_s2 && !act_s3) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH:  state_d = ST_RESULT;
			ST_RESULT: begin
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		start   = 1'b0;
		we      = 1'b0;
		rd_en   = 1'b0;
		scan_rd = 1'b0;
		emit    = 1'b0;
		rd_addr = addr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					pop = 1'b1;
					if (cmd.is_query) begin
						start = 1'b1;
					end else if (cmd.load_ok) begin
						we = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				rd_en   = 1'b1;
				scan_rd = 1'b1;
			end
			ST_DRAIN: begin
			end
			// reread the winner so its shared mark is current, also when nothing was found
			ST_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = best_q;
			end
			ST_RESULT: emit = !result_valid_q || !result_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ent_vld_q      <= '0;
			used_q         <= '0;
			last_nearest_q <= '0;
			act_s1         <= 1'b0;
			act_s2         <= 1'b0;
			act_s3         <= 1'b0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			act_s1  <= scan_rd;
			act_s2  <= act_s1 && elig;
			act_s3  <= act_s2;
			if (we) begin
				ent_vld_q[IDX_W'(cmd.index)] <= 1'b1;
			end
			if (start) begin
				found_q <= 1'b0;
			end else if (act_s3 && (!found_q || sum_s3 < best_d_q)) begin
				found_q <= 1'b1;
			end
			if (emit) begin
				used_q[best_q] <= 1'b1;
				last_nearest_q <= best_q;
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tr_q       <= cmd.red;
			tg_q       <= cmd.green;
			tb_q       <= cmd.blue;
			addr_q     <= '0;
			last_idx_q <= last_idx_c;
			best_q     <= last_nearest_q;
			best_d_q   <= '0;
		end else begin
			if (scan_rd) begin
				addr_q <= addr_q + 1'b1;
			end
			if (act_s3 && (!found_q || sum_s3 < best_d_q)) begin
				best_q   <= idx_s3;
				best_d_q <= sum_s3;
			end
		end
		if (rd_en) begin
			vld_s1 <= ent_vld_q[rd_addr];
			idx_s1 <= rd_addr;
		end
		idx_s2 <= idx_s1;
		dr_s2  <= abs_diff(ent_rd.red, tr_q);
		dg_s2  <= abs_diff(ent_rd.green, tg_q);
		db_s2  <= abs_diff(ent_rd.blue, tb_q);
		idx_s3 <= idx_s2;
		sum_s3 <= DIST_W'(dr_s2) + DIST_W'(dg_s2) + DIST_W'(db_s2);
		if (emit) begin
			result_q.nearest_entry    <= 8'(best_q);
			result_q.min_distance     <= found_q ? best_d_q : '0;
			result_q.found            <= found_q;
			result_q.first_shared_use <= vld_s1 && ent_rd.shared && !used_q[best_q];
		end
	end

	assign result_valid   = result_valid_q;
	assign result         = result_q;
	assign stat.idle      = (state_q == ST_IDLE);
	assign stat.in_result = (state_q == ST_RESULT);

endmodule

// File: hw/rtl/nearest_palette_colour_search.sv
// nearest palette colour search, L1 metric. a load writes one palette entry; a query walks
// the first N = min(2^palette_size_log2, 2^8, MAX_ENTRIES) entries through the colour memory
// read port one entry per cycle, then drains the pipeline, rereads the winner and holds the
// result; one request at a time in the engine, two more held in the queue. reset (arst_n,
// async low) clears marks, used flags, last answer and queue; size = 8. depends on npcs_pkg,
// npcs_front, npcs_queue, npcs_back, npcs_ram

module nearest_palette_colour_search import npcs_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  npcs_in_t           item,
	output logic               result_valid,
	input  logic               result_stall,
	output npcs_out_t          result
);

	logic [SIZE_W-1:0] size_q;
	logic              q_full, push, q_pop, q_not_empty;
	npcs_cmd_t         cmd_in, cmd_out;
	npcs_stat_t        stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PALETTE_SIZE_LOG2) ? PDATA_W'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == REG_PALETTE_SIZE_LOG2) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	npcs_front #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.cmd        (cmd_in)
	);

	npcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (cmd_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.dout      (cmd_out)
	);

	npcs_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.size_log2    (size_q),
		.cmd_valid    (q_not_empty),
		.cmd          (cmd_out),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.stat         (stat)
	);

	a_no_dist_when_missing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.min_distance == '0)
		else $error("distance reported without an eligible entry");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> {1'b0, result.nearest_entry} < CNT_W'(MAX_ENTRIES))
		else $error("nearest entry beyond palette depth");

	a_result_from_engine: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(stat.in_result))
		else $error("result appeared outside the result state");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> stat.idle && q_not_empty)
		else $error("queue popped while engine busy");

endmodule

// File: tb/nearest_palette_colour_search_tb.sv
// self-checking bench for nearest_palette_colour_search: bursty request driver, stalling
// result monitor, and an in-bench L1 nearest-entry predictor checked result by result
// depends on npcs_pkg and the nearest_palette_colour_search rtl

module nearest_palette_colour_search_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import npcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASE_ITEMS    = 48;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               item_valid;
	logic               item_stall;
	npcs_in_t           item;
	logic               result_valid;
	logic               result_stall;
	npcs_out_t          result;

	// predictor state
	npcs_entry_t       palette_copy [MAX_ENTRIES_DEF];
	bit                used_copy [MAX_ENTRIES_DEF];
	logic [7:0]        last_pick;
	logic [SIZE_W-1:0] size_lg_copy;

	npcs_in_t  request_queue[$];
	npcs_out_t pending_matches[$];

	int  match_errors  = 0;
	int  config_errors = 0;
	int  idle_cycles   = 0;
	bit  req_taken     = 1'b0;
	int  burst_left    = 1;
	int  gap_left      = 0;
	int  stall_span    = 0;
	int  stall_style   = 0;

	nearest_palette_colour_search i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned channel_gap(input int unsigned a, input int unsigned b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic void predict_colour_match(input npcs_in_t req);
		int unsigned tgt_r, tgt_g, tgt_b, gap_sum, best_dist, span;
		logic [7:0]  best;
		bit          hit;
		npcs_out_t   m;
		if (req.kind == KIND_LOAD) begin
			palette_copy[req.entry_index] = '{red: req.entry_red, green: req.entry_green,
				blue: req.entry_blue, exact: req.entry_exact, shared: req.entry_shared};
			return;
		end
		tgt_r = 32'(req.colour_code[2:0]) * 65535 / 7;
		tgt_g = 32'(req.colour_code[5:3]) * 65535 / 7;
		tgt_b = 32'(req.colour_code[7:6]) * 65535 / 3;
		// sizes above 8 saturate
		span = 1 << ((size_lg_copy > LG_MAX) ? LG_MAX : size_lg_copy);
		if (span > MAX_ENTRIES_DEF)
			span = MAX_ENTRIES_DEF;
		best = last_pick;
		best_dist = 0;
		hit = 1'b0;
		for (int i = 0; i < int'(span); i++) begin
			if (palette_copy[i].exact || palette_copy[i].shared) begin
				gap_sum = channel_gap(palette_copy[i].red, tgt_r) +
					channel_gap(palette_copy[i].green, tgt_g) +
					channel_gap(palette_copy[i].blue, tgt_b);
				if (!hit || gap_sum < best_dist) begin
					hit = 1'b1;
					best_dist = gap_sum;
					best = 8'(i);
				end
			end
		end
		m.nearest_entry = best;
		m.min_distance = hit ? DIST_W'(best_dist) : '0;
		m.found = hit;
		m.first_shared_use = palette_copy[best].shared && !used_copy[best];
		used_copy[best] = 1'b1;
		last_pick = best;
		pending_matches.push_back(m);
	endfunction

	function automatic logic [CH_W-1:0] pick_intensity();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 1) ? 65535 : 0;
			// close to one of the expansion steps, so distances come out near zero
			1: begin
				v = int'($urandom_range(0, 7) * 65535 / 7) + int'($urandom_range(0, 64)) - 32;
				v = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
			end
			default: v = int'($urandom_range(0, 65535));
		endcase
		return CH_W'(v);
	endfunction

	function automatic npcs_in_t make_query(input logic [7:0] code);
		npcs_in_t r;
		r.kind = KIND_QUERY;
		r.entry_index = 8'($urandom);
		r.entry_red = 16'($urandom);
		r.entry_green = 16'($urandom);
		r.entry_blue = 16'($urandom);
		r.entry_exact = 1'($urandom);
		r.entry_shared = 1'($urandom);
		r.colour_code = code;
		return r;
	endfunction

	function automatic npcs_in_t make_load(input logic [7:0] idx, input logic [CH_W-1:0] red,
		input logic [CH_W-1:0] green, input logic [CH_W-1:0] blue, input logic exact,
		input logic shared);
		npcs_in_t r;
		r.kind = KIND_LOAD;
		r.entry_index = idx;
		r.entry_red = red;
		r.entry_green = green;
		r.entry_blue = blue;
		r.entry_exact = exact;
		r.entry_shared = shared;
		r.colour_code = 8'($urandom);
		return r;
	endfunction

	function automatic npcs_in_t random_request(input int span);
		logic [7:0] idx;
		idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, span - 1));
		if ($urandom_range(0, 99) < 45)
			return make_load(idx, pick_intensity(), pick_intensity(), pick_intensity(),
				1'($urandom), 1'($urandom));
		return make_query(8'($urandom));
	endfunction

	task automatic set_palette_size(input logic [SIZE_W-1:0] lg);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_PALETTE_SIZE_LOG2, 2'b00};
		pwdata <= PDATA_W'(lg);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		size_lg_copy = lg;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[SIZE_W-1:0] !== lg) begin
			config_errors++;
			$display("palette size readback: expected %0d, got %0d", lg, prdata[SIZE_W-1:0]);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// everything sent, every match back, then let trailing loads finish
	// checked at the rising edge, where the driver's outputs have settled
	task automatic wait_idle();
		do @(posedge clk);
		while (request_queue.size() != 0 || item_valid || pending_matches.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// request driver: bursts with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || req_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (request_queue.size() != 0) begin
				item <= request_queue.pop_front();
				item_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					if ($urandom_range(0, 3) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 300 : 12);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result stall pattern: runs of no stall, random stall, or solid stall
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_span = $urandom_range(1, 40);
			stall_style = $urandom_range(0, 9);
		end
		stall_span--;
		result_stall <= (stall_style >= 7) ? 1'b1 :
			(stall_style >= 4) ? 1'($urandom_range(0, 1)) : 1'b0;
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		npcs_out_t want;
		bit        busy;
		busy = 1'b0;
		if (arst_n && item_valid && !item_stall) begin
			predict_colour_match(item);
			busy = 1'b1;
		end
		req_taken <= arst_n && item_valid && !item_stall;
		if (arst_n && result_valid && !result_stall) begin
			busy = 1'b1;
			if (pending_matches.size() == 0) begin
				match_errors++;
				if (match_errors <= REPORT_LIMIT)
					$display("unexpected result: entry %0d distance %0d found %0b first-shared %0b",
						result.nearest_entry, result.min_distance, result.found,
						result.first_shared_use);
			end else begin
				want = pending_matches.pop_front();
				if (result.nearest_entry !== want.nearest_entry ||
					result.min_distance !== want.min_distance ||
					result.found !== want.found ||
					result.first_shared_use !== want.first_shared_use) begin
					match_errors++;
					if (match_errors <= REPORT_LIMIT)
						$display({"result mismatch: expected entry %0d distance %0d found %0b ",
							"first-shared %0b, got entry %0d distance %0d found %0b ",
							"first-shared %0b"}, want.nearest_entry, want.min_distance,
							want.found, want.first_shared_use, result.nearest_entry,
							result.min_distance, result.found, result.first_shared_use);
				end
			end
		end
		if (busy || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [SIZE_W-1:0] phase_sizes [8];
		int                span;
		phase_sizes = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd2, 4'd12, 4'd5};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
			palette_copy[i] = '0;
			used_copy[i] = 1'b0;
		end
		last_pick = '0;
		size_lg_copy = SIZE_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		set_palette_size(4'd8);
		// empty palette: nothing eligible, previous answer repeated
		request_queue.push_back(make_query(8'h00));
		request_queue.push_back(make_load(8'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1));
		request_queue.push_back(make_load(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
		request_queue.push_back(make_query(8'hFF));
		// first and second use of a shared entry
		request_queue.push_back(make_query(8'h00));
		request_queue.push_back(make_query(8'h00));
		// reload keeps the used mark
		request_queue.push_back(make_load(8'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1));
		request_queue.push_back(make_query(8'h00));
		// equal distance: lowest index wins
		request_queue.push_back(make_load(8'd128, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1));
		request_queue.push_back(make_query(8'h00));
		// drop eligibility, then the largest possible distance
		request_queue.push_back(make_load(8'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
		request_queue.push_back(make_load(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
		request_queue.push_back(make_query(8'hFF));
		request_queue.push_back(make_load(8'd170, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0));
		request_queue.push_back(make_load(8'd85, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b1));
		request_queue.push_back(make_query(8'h5A));
		request_queue.push_back(make_query(8'hA5));
		request_queue.push_back(make_query(8'h07));
		request_queue.push_back(make_query(8'h38));
		request_queue.push_back(make_query(8'hC0));
		request_queue.push_back(make_load(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
		request_queue.push_back(make_query(8'hFF));
		wait_idle();

		foreach (phase_sizes[p]) begin
			set_palette_size(phase_sizes[p]);
			span = 1 << ((phase_sizes[p] > LG_MAX) ? LG_MAX : phase_sizes[p]);
			// with size zero and entry 0 ineligible this query finds nothing
			if (phase_sizes[p] == 0)
				request_queue.push_back(make_query(8'($urandom)));
			for (int k = 0; k < PHASE_ITEMS; k++)
				request_queue.push_back(random_request(span));
			wait_idle();
		end

		if (match_errors == 0 && config_errors == 0 && pending_matches.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: nearest_palette_colour_search.f
hw/rtl/npcs_pkg.sv
hw/rtl/npcs_ram.sv
hw/rtl/npcs_front.sv
hw/rtl/npcs_queue.sv
hw/rtl/npcs_back.sv
hw/rtl/nearest_palette_colour_search.sv
tb/nearest_palette_colour_search_tb.sv
